@@ rtl/rds_ps_pkg.sv @@
// rds_ps_pkg: shared types, constants and helpers for the rds station name assembler
// no dependencies; used by every rds_ps module and the top level

package rds_ps_pkg;

    localparam int NAME_CHARS = 8;

    localparam logic [4:0] GROUP_TYPE_0A = 5'd0;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef logic [7:0] char_t;

    // classified group as handed from the front end to the back end
    typedef struct packed {
        logic       use_group;
        logic [1:0] segment;
        char_t      char_hi;
        char_t      char_lo;
    } ps_cmd_t;

    function automatic logic is_space(char_t c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic char_t fold_cr(char_t c);
        return (c == CHAR_CR) ? CHAR_NUL : c;
    endfunction

endpackage

@@ rtl/rds_ps_group_if.sv @@
// rds_ps_group_if: input channel carrying one decoded rds group per transaction
// depends on nothing; valid/ready handshake

interface rds_ps_group_if;
    logic        valid;
    logic        ready;
    logic [4:0]  group_type;
    logic [15:0] block_b;
    logic [15:0] block_d;

    modport source (output valid, group_type, block_b, block_d, input ready);
    modport sink   (input valid, group_type, block_b, block_d, output ready);
endinterface

@@ rtl/rds_ps_result_if.sv @@
// rds_ps_result_if: output channel carrying one station name report per transaction
// depends on nothing; valid/ready handshake

interface rds_ps_result_if;
    logic        valid;
    logic        ready;
    logic        name_done_now;
    logic        name_known;
    logic [63:0] name_text;
    logic [3:0]  name_length;
    logic [3:0]  fill_position;

    modport source (output valid, name_done_now, name_known, name_text, name_length,
                    fill_position, input ready);
    modport sink   (input valid, name_done_now, name_known, name_text, name_length,
                    fill_position, output ready);
endinterface

@@ rtl/rds_ps_front.sv @@
// rds_ps_front: accepts groups, classifies them and registers the command
// depends on rds_ps_pkg and rds_ps_group_if

module rds_ps_front
(
    input  logic                clk,
    input  logic                rst_n,
    rds_ps_group_if.sink        grp,
    output logic                cmd_valid,
    output rds_ps_pkg::ps_cmd_t cmd,
    input  logic                cmd_ready
);

    logic                vld_reg;
    logic                vld_next;
    rds_ps_pkg::ps_cmd_t cmd_reg;
    rds_ps_pkg::ps_cmd_t cmd_next;
    logic                take;

    assign grp.ready = !vld_reg || cmd_ready;
    assign take      = grp.valid && grp.ready;

    always_comb
    begin
        cmd_next.use_group = (grp.group_type == rds_ps_pkg::GROUP_TYPE_0A);
        cmd_next.segment   = grp.block_b[1:0];
        cmd_next.char_hi   = rds_ps_pkg::fold_cr(grp.block_d[15:8]);
        cmd_next.char_lo   = rds_ps_pkg::fold_cr(grp.block_d[7:0]);
    end

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

endmodule

@@ rtl/rds_ps_queue.sv @@
// rds_ps_queue: two-entry command queue between front and back end
// depends on rds_ps_pkg

module rds_ps_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  rds_ps_pkg::ps_cmd_t push_cmd,
    output logic                push_ready,
    output logic                pop_valid,
    output rds_ps_pkg::ps_cmd_t pop_cmd,
    input  logic                pop_ready
);

    rds_ps_pkg::ps_cmd_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/rds_ps_back.sv @@
// rds_ps_back: carries out commands on the partial name, trims completed names
// and holds the result register; depends on rds_ps_pkg and rds_ps_result_if

module rds_ps_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  rds_ps_pkg::ps_cmd_t cmd,
    output logic                cmd_ready,
    rds_ps_result_if.source     result
);

    localparam logic [3:0] NAME_END = 4'(rds_ps_pkg::NAME_CHARS);

    rds_ps_pkg::char_t chars_reg  [rds_ps_pkg::NAME_CHARS];
    rds_ps_pkg::char_t chars_next [rds_ps_pkg::NAME_CHARS];
    logic [3:0]        np_reg;
    logic [3:0]        np_next;
    logic [63:0]       saved_name_reg;
    logic [63:0]       saved_name_next;
    logic [3:0]        saved_len_reg;
    logic [3:0]        saved_len_next;
    logic              saved_valid_reg;
    logic              saved_valid_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              done_reg;

    logic              take;
    logic              finish;
    logic [3:0]        count;
    logic [3:0]        pos;
    logic [rds_ps_pkg::NAME_CHARS-1:0] keep;
    logic [2:0]        first;
    logic [3:0]        last;
    logic [63:0]       packed_word;
    logic [63:0]       trim_text;
    logic [3:0]        trim_len;

    assign cmd_ready = !out_vld_reg || result.ready;
    assign take      = cmd_valid && cmd_ready;
    assign pos       = {1'b0, cmd.segment, 1'b0};

    // apply one group to the partial name
    always_comb
    begin
        chars_next = chars_reg;
        np_next    = np_reg;
        finish     = 1'b0;
        count      = 4'd0;
        if (cmd.use_group)
        begin
            if ((cmd.segment == 2'd0) || (pos == np_reg))
            begin
                if (cmd.segment == 2'd0)
                begin
                    for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
                    begin
                        chars_next[i] = rds_ps_pkg::CHAR_NUL;
                    end
                end
                chars_next[{cmd.segment, 1'b0}] = cmd.char_hi;
                if (cmd.char_hi == rds_ps_pkg::CHAR_NUL)
                begin
                    finish = 1'b1;
                    count  = pos;
                end
                else
                begin
                    chars_next[{cmd.segment, 1'b1}] = cmd.char_lo;
                    if (cmd.char_lo == rds_ps_pkg::CHAR_NUL)
                    begin
                        finish = 1'b1;
                        count  = pos + 4'd1;
                    end
                    else if ((pos + 4'd2) >= NAME_END)
                    begin
                        finish = 1'b1;
                        count  = NAME_END;
                    end
                end
                np_next = finish ? 4'd0 : pos + 4'd2;
            end
            else
            begin
                for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
                begin
                    chars_next[i] = rds_ps_pkg::CHAR_NUL;
                end
                np_next = 4'd0;
            end
        end
    end

    // whitespace trim of the first count characters
    always_comb
    begin
        for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
        begin
            keep[i] = (4'(i) < count) && !rds_ps_pkg::is_space(chars_next[i]);
        end
        first = 3'd0;
        for (int i = rds_ps_pkg::NAME_CHARS - 1; i >= 0; i--)
        begin
            if (keep[i])
            begin
                first = 3'(i);
            end
        end
        last = 4'd0;
        for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
        begin
            if (keep[i])
            begin
                last = 4'(i + 1);
            end
        end
        packed_word = 64'd0;
        for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
        begin
            if (4'(i) < last)
            begin
                packed_word[63 - 8*i -: 8] = chars_next[i];
            end
        end
        if (keep == '0)
        begin
            trim_text = 64'd0;
            trim_len  = 4'd0;
        end
        else
        begin
            trim_text = packed_word << {first, 3'b000};
            trim_len  = last - {1'b0, first};
        end
    end

    always_comb
    begin
        saved_name_next  = saved_name_reg;
        saved_len_next   = saved_len_reg;
        saved_valid_next = saved_valid_reg;
        if (finish)
        begin
            saved_name_next  = trim_text;
            saved_len_next   = trim_len;
            saved_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rds_ps_pkg::NAME_CHARS; i++)
            begin
                chars_reg[i] <= rds_ps_pkg::CHAR_NUL;
            end
            np_reg          <= 4'd0;
            saved_name_reg  <= 64'd0;
            saved_len_reg   <= 4'd0;
            saved_valid_reg <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (take)
            begin
                chars_reg       <= chars_next;
                np_reg          <= np_next;
                saved_name_reg  <= saved_name_next;
                saved_len_reg   <= saved_len_next;
                saved_valid_reg <= saved_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            done_reg <= finish;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.name_done_now = done_reg;
    assign result.name_known    = saved_valid_reg;
    assign result.name_text     = saved_name_reg;
    assign result.name_length   = saved_len_reg;
    assign result.fill_position = np_reg;

endmodule

@@ rtl/rds_station_name_assembler.sv @@
// rds_station_name_assembler: top level of the rds group 0a station name assembler
// depends on rds_ps_pkg, rds_ps_group_if, rds_ps_result_if, rds_ps_front,
// rds_ps_queue and rds_ps_back
//
// usage:
//   grp carries one decoded rds group per transaction (group_type, block_b,
//   block_d); only type 0a groups change the name state, others just report it
//   result carries exactly one report per group, in order: name_done_now,
//   name_known, the trimmed name text and length, and the next fill position
//   result is registered: each group passes the front register, the command queue
//   and the result register in that order; one group per cycle is sustained while
//   result is not stalled; the back end applies each taken group to the name
//   when result is stalled the result register holds, the back end stops
//   pulling from the two-entry queue, and grp.ready drops once the queue and
//   front register are full; no report is lost or repeated
//   reset clears the partial name, the fill position and the saved name, and
//   empties the queue; grp.ready is high in the first cycle after reset

module rds_station_name_assembler
(
    input  logic            clk,
    input  logic            rst_n,
    rds_ps_group_if.sink    grp,
    rds_ps_result_if.source result
);

    logic                front_valid;
    rds_ps_pkg::ps_cmd_t front_cmd;
    logic                front_ready;
    logic                back_valid;
    rds_ps_pkg::ps_cmd_t back_cmd;
    logic                back_ready;

    rds_ps_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    rds_ps_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    rds_ps_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .result    (result)
    );

endmodule

@@ test/tb_rds_station_name_assembler.sv @@
// tb_rds_station_name_assembler: self-checking bench for the rds group 0a station name assembler
// depends on rds_ps_pkg, rds_ps_group_if, rds_ps_result_if and rds_station_name_assembler
// a scoreboard class tracks the name state per accepted group and checks every report in order

module tb_rds_station_name_assembler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        done;
        logic        known;
        logic [63:0] text;
        logic [3:0]  length;
        logic [3:0]  fill;
    } name_report_t;

    class ps_name_scoreboard;
        rds_ps_pkg::char_t partial [rds_ps_pkg::NAME_CHARS];
        logic [3:0]   next_pos;
        bit           partial_done;
        logic [63:0]  saved_text;
        logic [3:0]   saved_len;
        bit           saved_ok;
        name_report_t due_reports [$];
        int           errors;

        function new();
            clear_partial();
            saved_text = '0;
            saved_len  = '0;
            saved_ok   = 1'b0;
            errors     = 0;
        endfunction

        function void clear_partial();
            foreach (partial[i])
                partial[i] = rds_ps_pkg::CHAR_NUL;
            next_pos     = '0;
            partial_done = 1'b0;
        endfunction

        function bit blank(rds_ps_pkg::char_t c);
            return (c == rds_ps_pkg::CHAR_SPACE) ||
                   (c >= rds_ps_pkg::CHAR_TAB && c <= rds_ps_pkg::CHAR_CR);
        endfunction

        // trim whitespace on both ends and save the name
        function void close_name(int count);
            int          first;
            int          last;
            int          i;
            logic [63:0] text;
            first = 0;
            last  = count;
            text  = '0;
            while (first < last && blank(partial[first]))
                first++;
            while (last > first && blank(partial[last - 1]))
                last--;
            for (i = first; i < last; i++)
                text |= 64'(partial[i]) << (56 - 8 * (i - first));
            saved_text   = text;
            saved_len    = 4'(last - first);
            saved_ok     = 1'b1;
            partial_done = 1'b1;
        endfunction

        function bit take_char(rds_ps_pkg::char_t c);
            int p;
            if (partial_done)
                return 1'b0;
            if (c == rds_ps_pkg::CHAR_CR)
                c = rds_ps_pkg::CHAR_NUL;
            p = next_pos;
            if (p >= rds_ps_pkg::NAME_CHARS)
            begin
                close_name(rds_ps_pkg::NAME_CHARS);
                return 1'b1;
            end
            partial[p] = c;
            next_pos   = 4'(p + 1);
            if (c == rds_ps_pkg::CHAR_NUL)
            begin
                close_name(p);
                return 1'b1;
            end
            if (next_pos >= rds_ps_pkg::NAME_CHARS)
            begin
                close_name(rds_ps_pkg::NAME_CHARS);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_group(logic [4:0] gt, logic [15:0] b, logic [15:0] d);
            name_report_t r;
            logic [3:0]   pos;
            bit           done;
            done = 1'b0;
            if (gt == rds_ps_pkg::GROUP_TYPE_0A)
            begin
                pos = {1'b0, b[1:0], 1'b0};
                if (pos == 0)
                    clear_partial();
                if (pos == next_pos)
                begin
                    if (take_char(d[15:8]))
                        done = 1'b1;
                    if (take_char(d[7:0]))
                        done = 1'b1;
                    if (partial_done)
                        next_pos = '0;
                end
                else
                begin
                    clear_partial();
                end
            end
            r.done   = done;
            r.known  = saved_ok;
            r.text   = saved_text;
            r.length = saved_len;
            r.fill   = next_pos;
            due_reports.push_back(r);
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_report(name_report_t got);
            name_report_t want;
            if (due_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with none expected, actual %h", $time, got);
                return;
            end
            want = due_reports.pop_front();
            flag("name_done_now", want.done, got.done);
            flag("name_known", want.known, got.known);
            flag("name_text", want.text, got.text);
            flag("name_length", want.length, got.length);
            flag("fill_position", want.fill, got.fill);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   hold_left;

    ps_name_scoreboard book;

    rds_ps_group_if  grp ();
    rds_ps_result_if result ();

    rds_station_name_assembler u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .grp    (grp),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("rds_station_name_assembler regression: fail");
        $finish;
    end

    function automatic rds_ps_pkg::char_t pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return rds_ps_pkg::CHAR_NUL;
        if (r == 1)
            return rds_ps_pkg::CHAR_CR;
        if (r <= 4)
            return ($urandom_range(0, 1) != 0) ? rds_ps_pkg::CHAR_SPACE
                                                : 8'($urandom_range(9, 13));
        if (r <= 6)
            return 8'($urandom);
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    task automatic send_group(logic [4:0] gt, logic [15:0] b, logic [15:0] d);
        @(negedge clk);
        while (!steady && hold_left == 0 && $urandom_range(0, 99) < 31)
        begin
            grp.valid <= 1'b0;
            @(negedge clk);
        end
        grp.valid      <= 1'b1;
        grp.group_type <= gt;
        grp.block_b    <= b;
        grp.block_d    <= d;
        do
            @(posedge clk);
        while (grp.ready !== 1'b1);
        book.note_group(gt, b, d);
    endtask

    // receiver side, including the long hold-off
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result.ready <= steady || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid === 1'b1 && result.ready === 1'b1)
            book.check_report(name_report_t'{result.name_done_now, result.name_known,
                                             result.name_text, result.name_length,
                                             result.fill_position});
    end

    initial
    begin
        int          zero_a;
        int          n;
        int          seg;
        bit          squeezed;
        logic [4:0]  gt;
        logic [15:0] b;
        book           = new();
        rst_n          = 1'b0;
        steady         = 1'b0;
        hold_left      = 0;
        squeezed       = 1'b0;
        grp.valid      = 1'b0;
        grp.group_type = '0;
        grp.block_b    = '0;
        grp.block_d    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full eight character name
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h4142);
        send_group(5'd31, 16'hFFFF, 16'hFFFF);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h4344);
        send_group(5'd1, 16'h0000, 16'h0000);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0002, 16'h4546);
        send_group(5'd16, 16'h0003, 16'h0000);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0003, 16'h4748);
        // leading whitespace, carriage return ends it
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h2009);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h580D);
        // terminator in high byte
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h0041);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h0D41);
        // all whitespace
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h2020);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h0A0B);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0002, 16'h0C20);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0003, 16'h0920);
        // out of order segments
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h4849);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0002, 16'h4A4B);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h4C4D);
        // raw high bytes
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'hFFFC, 16'hFF80);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'hAAA9, 16'hC3A9);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h5556, 16'h7F01);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'hFFFF, 16'hFFFF);
        // non-zero segment right after completion, then out of order with zero data
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h4E4F);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'hFFFF, 16'h0000);
        // trailing and leading spaces trimmed
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0000, 16'h2052);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0001, 16'h4453);
        send_group(rds_ps_pkg::GROUP_TYPE_0A, 16'h0002, 16'h2000);

        zero_a = 0;
        while (zero_a < 700)
        begin
            steady = (zero_a >= 250 && zero_a < 370);
            if (zero_a >= 500 && !squeezed)
            begin
                hold_left = 90;
                squeezed  = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 4;
                for (seg = 0; seg < n; seg++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_group(5'($urandom_range(1, 31)), 16'($urandom), 16'($urandom));
                    b      = 16'($urandom);
                    b[1:0] = seg[1:0];
                    send_group(rds_ps_pkg::GROUP_TYPE_0A, b, {pick_char(), pick_char()});
                    zero_a++;
                end
            end
            else
            begin
                gt = ($urandom_range(0, 1) != 0) ? rds_ps_pkg::GROUP_TYPE_0A
                                                  : 5'($urandom_range(0, 31));
                send_group(gt, 16'($urandom), 16'($urandom));
                if (gt == rds_ps_pkg::GROUP_TYPE_0A)
                    zero_a++;
            end
        end
        steady = 1'b0;
        @(negedge clk);
        grp.valid <= 1'b0;

        while (book.due_reports.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (book.errors == 0)
            $display("rds_station_name_assembler regression: pass");
        else
            $display("rds_station_name_assembler regression: fail");
        $finish;
    end

endmodule
